// File: src/ntw_pkg.sv
package ntw_pkg;

	// word codes
	localparam logic [4:0] W_ZERO     = 5'd0;
	localparam logic [4:0] W_TEN      = 5'd10;
	localparam logic [4:0] W_TENS_OFS = 5'd18;
	localparam logic [4:0] W_HUNDRED  = 5'd28;
	localparam logic [4:0] W_THOUSAND = 5'd29;
	localparam logic [4:0] W_MILLION  = 5'd30;
	localparam logic [4:0] W_BILLION  = 5'd31;

	localparam int VALUE_W = 31;
	localparam int WORD_W  = 5;
	localparam int STEP_W  = 5;

	// microcode operations
	typedef enum logic [2:0] {
		OP_DIGIT,
		OP_ZERO,
		OP_HUND,
		OP_HWORD,
		OP_TENS,
		OP_ONES,
		OP_SCALE,
		OP_END
	} ntw_op_t;

	// one control word: operation, argument (power index or scale word), jump target
	typedef struct packed {
		ntw_op_t           op;
		logic [4:0]        arg;
		logic [STEP_W-1:0] jmp;
	} ntw_uword_t;

	// d times ten to the k, wide enough for nine billion
	function automatic logic [34:0] pow_mult(input logic [3:0] k, input logic [3:0] d);
		logic [31:0] p;
		case (k)
			4'd0:    p = 32'd1;
			4'd1:    p = 32'd10;
			4'd2:    p = 32'd100;
			4'd3:    p = 32'd1000;
			4'd4:    p = 32'd10000;
			4'd5:    p = 32'd100000;
			4'd6:    p = 32'd1000000;
			4'd7:    p = 32'd10000000;
			4'd8:    p = 32'd100000000;
			4'd9:    p = 32'd1000000000;
			default: p = 32'd0;
		endcase
		return {3'd0, p} * {31'd0, d};
	endfunction

	// control program: ten digit steps, zero check, four groups, end
	function automatic ntw_uword_t ntw_ucode(input logic [STEP_W-1:0] step);
		ntw_uword_t u;
		case (step)
			5'd0:    u = '{op: OP_DIGIT, arg: 5'd9, jmp: 5'd0};
			5'd1:    u = '{op: OP_DIGIT, arg: 5'd8, jmp: 5'd0};
			5'd2:    u = '{op: OP_DIGIT, arg: 5'd7, jmp: 5'd0};
			5'd3:    u = '{op: OP_DIGIT, arg: 5'd6, jmp: 5'd0};
			5'd4:    u = '{op: OP_DIGIT, arg: 5'd5, jmp: 5'd0};
			5'd5:    u = '{op: OP_DIGIT, arg: 5'd4, jmp: 5'd0};
			5'd6:    u = '{op: OP_DIGIT, arg: 5'd3, jmp: 5'd0};
			5'd7:    u = '{op: OP_DIGIT, arg: 5'd2, jmp: 5'd0};
			5'd8:    u = '{op: OP_DIGIT, arg: 5'd1, jmp: 5'd0};
			5'd9:    u = '{op: OP_DIGIT, arg: 5'd0, jmp: 5'd0};
			5'd10:   u = '{op: OP_ZERO,  arg: 5'd0, jmp: 5'd30};
			5'd11:   u = '{op: OP_HUND,  arg: 5'd0, jmp: 5'd16};
			5'd12:   u = '{op: OP_HWORD, arg: 5'd0, jmp: 5'd0};
			5'd13:   u = '{op: OP_TENS,  arg: 5'd0, jmp: 5'd0};
			5'd14:   u = '{op: OP_ONES,  arg: 5'd0, jmp: 5'd0};
			5'd15:   u = '{op: OP_SCALE, arg: W_BILLION, jmp: 5'd0};
			5'd16:   u = '{op: OP_HUND,  arg: 5'd0, jmp: 5'd21};
			5'd17:   u = '{op: OP_HWORD, arg: 5'd0, jmp: 5'd0};
			5'd18:   u = '{op: OP_TENS,  arg: 5'd0, jmp: 5'd0};
			5'd19:   u = '{op: OP_ONES,  arg: 5'd0, jmp: 5'd0};
			5'd20:   u = '{op: OP_SCALE, arg: W_MILLION, jmp: 5'd0};
			5'd21:   u = '{op: OP_HUND,  arg: 5'd0, jmp: 5'd26};
			5'd22:   u = '{op: OP_HWORD, arg: 5'd0, jmp: 5'd0};
			5'd23:   u = '{op: OP_TENS,  arg: 5'd0, jmp: 5'd0};
			5'd24:   u = '{op: OP_ONES,  arg: 5'd0, jmp: 5'd0};
			5'd25:   u = '{op: OP_SCALE, arg: W_THOUSAND, jmp: 5'd0};
			5'd26:   u = '{op: OP_HUND,  arg: 5'd0, jmp: 5'd30};
			5'd27:   u = '{op: OP_HWORD, arg: 5'd0, jmp: 5'd0};
			5'd28:   u = '{op: OP_TENS,  arg: 5'd0, jmp: 5'd0};
			5'd29:   u = '{op: OP_ONES,  arg: 5'd0, jmp: 5'd0};
			default: u = '{op: OP_END,   arg: 5'd0, jmp: 5'd0};
		endcase
		return u;
	endfunction

endpackage

// File: src/ntw_if.sv
// input channel: one number per beat
interface ntw_in_if;
	logic        valid;
	logic        ready;
	logic [30:0] value;

	modport source (output valid, output value, input ready);
	modport sink   (input valid, input value, output ready);
endinterface

// output channel: one word code per beat
interface ntw_out_if;
	logic       valid;
	logic       ready;
	logic [4:0] word;
	logic       last;

	modport source (output valid, output word, output last, input ready);
	modport sink   (input valid, input word, input last, output ready);
endinterface

// File: src/number_to_word_tokens_top.sv
// Spells a 31-bit unsigned number as English word codes in reading order.
// in_ch:  valid/ready channel, one number per beat (value).
// out_ch: valid/ready channel, one word code per beat (word), last set on
//         the final word of each number. Zero gives the single word Zero.
// A microcoded sequencer steps through a 31-entry control table: ten steps
// take out one decimal digit each (compare against nine multiples of a power
// of ten, subtract), one step checks for zero, then each three-digit group
// runs five steps (hundreds digit, Hundred, tens/teen, ones, scale word;
// the unit group has no scale word), or one step when the group is zero,
// and a final step flushes the last word.
// in_ch.ready is high while no number is in progress; the last word may still
// wait in the output register while the next number is accepted.
// Words pass through a one-word pending register and an output register; when
// the receiver holds ready low, the sequencer stops at the next step that
// produces a word or ends the number, and resumes once the output register drains.
// Reset clears the sequencer and empties both registers; no words are lost
// or repeated otherwise.
module number_to_word_tokens_top (
	input  logic             clk,
	input  logic             arst_n,
	ntw_in_if.sink           in_ch,
	ntw_out_if.source        out_ch
);
	import ntw_pkg::*;

	logic                     busy_q;
	logic [STEP_W-1:0]        step_q;
	logic [VALUE_W-1:0]       rem_q;
	logic [11:0][3:0]         dig_q;
	logic                     pend_v_q;
	logic [WORD_W-1:0]        pend_w_q;
	logic                     out_v_q;
	logic [WORD_W-1:0]        out_w_q;
	logic                     out_l_q;

	ntw_uword_t               uw;
	logic [3:0]               h, t, o;
	logic                     grp_nz;
	logic [3:0]               dnew;
	logic [34:0]              dsub;
	logic [VALUE_W-1:0]       rem_next;
	logic                     emit, jump, shift_dig, shift_grp, fin;
	logic [WORD_W-1:0]        w_emit;
	logic                     room, need_room, go, load, in_acc;

	assign uw     = ntw_ucode(step_q);
	assign h      = dig_q[11];
	assign t      = dig_q[10];
	assign o      = dig_q[9];
	assign grp_nz = (h != 4'd0) || (t != 4'd0) || (o != 4'd0);

	// take out one decimal digit at the power the control word names
	always_comb begin
		dnew = 4'd0;
		dsub = '0;
		for (int i = 1; i < 10; i++) begin
			if ({4'd0, rem_q} >= pow_mult(uw.arg[3:0], 4'(i))) begin
				dnew = 4'(i);
				dsub = pow_mult(uw.arg[3:0], 4'(i));
			end
		end
		rem_next = rem_q - dsub[VALUE_W-1:0];
	end

	// decode the current control word
	always_comb begin
		emit      = 1'b0;
		w_emit    = W_ZERO;
		jump      = 1'b0;
		shift_dig = 1'b0;
		shift_grp = 1'b0;
		fin       = 1'b0;
		case (uw.op)
			OP_DIGIT: shift_dig = 1'b1;
			OP_ZERO: begin
				if (dig_q == '0) begin
					emit   = 1'b1;
					w_emit = W_ZERO;
					jump   = 1'b1;
				end
			end
			OP_HUND: begin
				if (!grp_nz) begin
					jump      = 1'b1;
					shift_grp = 1'b1;
				end else if (h != 4'd0) begin
					emit   = 1'b1;
					w_emit = {1'b0, h};
				end
			end
			OP_HWORD: begin
				if (h != 4'd0) begin
					emit   = 1'b1;
					w_emit = W_HUNDRED;
				end
			end
			OP_TENS: begin
				if (t == 4'd1) begin
					emit   = 1'b1;
					w_emit = W_TEN + {1'b0, o};
				end else if (t >= 4'd2) begin
					emit   = 1'b1;
					w_emit = W_TENS_OFS + {1'b0, t};
				end else if (o != 4'd0) begin
					emit   = 1'b1;
					w_emit = {1'b0, o};
				end
			end
			OP_ONES: begin
				if (t >= 4'd2 && o != 4'd0) begin
					emit   = 1'b1;
					w_emit = {1'b0, o};
				end
			end
			OP_SCALE: begin
				emit      = 1'b1;
				w_emit    = uw.arg;
				shift_grp = 1'b1;
			end
			OP_END: fin = 1'b1;
			default: fin = 1'b1;
		endcase
	end

	// advance only when a word that must move out has a place to go
	assign room      = !out_v_q || out_ch.ready;
	assign need_room = pend_v_q && (emit || fin);
	assign go        = busy_q && (!need_room || room);
	assign load      = go && need_room;
	assign in_acc    = in_ch.valid && in_ch.ready;

	assign in_ch.ready  = !busy_q;
	assign out_ch.valid = out_v_q;
	assign out_ch.word  = out_w_q;
	assign out_ch.last  = out_l_q;

	// sequencer control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q   <= 1'b0;
			step_q   <= '0;
			pend_v_q <= 1'b0;
			out_v_q  <= 1'b0;
		end else begin
			if (in_acc) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (go) begin
				if (fin) begin
					busy_q <= 1'b0;
					step_q <= '0;
				end else if (jump) begin
					step_q <= uw.jmp;
				end else begin
					step_q <= STEP_W'(step_q + 1'b1);
				end
			end
			if (go && emit) begin
				pend_v_q <= 1'b1;
			end else if (go && fin) begin
				pend_v_q <= 1'b0;
			end
			if (load) begin
				out_v_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	// datapath: remainder, digit shift line, pending word, output word
	always_ff @(posedge clk) begin
		if (in_acc) begin
			rem_q <= in_ch.value;
			dig_q <= '0;
		end else if (go) begin
			if (shift_dig) begin
				rem_q <= rem_next;
				dig_q <= {dig_q[10:0], dnew};
			end else if (shift_grp) begin
				dig_q <= {dig_q[8:0], 12'd0};
			end
		end
		if (go && emit) begin
			pend_w_q <= w_emit;
		end
		if (load) begin
			out_w_q <= pend_w_q;
			out_l_q <= fin;
		end
	end

`ifndef NO_ASSERTIONS
	// no word is pending once the sequencer is idle
	a_idle_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!busy_q |-> !pend_v_q)
		else $error("pending word while idle");

	// digit extraction produces no words
	a_digit_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(busy_q && uw.op == OP_DIGIT) |-> !pend_v_q)
		else $error("word pending during digit extraction");

	// the current group holds decimal digits only
	a_bcd: assert property (@(posedge clk) disable iff (!arst_n)
		(busy_q && uw.op == OP_HUND) |-> (h <= 4'd9 && t <= 4'd9 && o <= 4'd9))
		else $error("group digit out of range");

	// a finished number leaves its final word marked last
	a_last: assert property (@(posedge clk) disable iff (!arst_n)
		(go && fin && pend_v_q) |=> (out_v_q && out_l_q))
		else $error("final word not marked last");
`endif

endmodule

// File: tb/number_to_word_tokens_top_tb.sv
`timescale 1ns / 1ps

module number_to_word_tokens_top_tb;
	import ntw_pkg::*;

	localparam int CYCLE_LIMIT  = 400000;
	localparam int RANDOM_COUNT = 310;
	localparam int DRAIN_CYCLES = 40;
	localparam longint VALUE_MAX = 64'd2147483647;

	typedef struct packed {
		logic [WORD_W-1:0] word;
		logic              last;
	} word_beat_t;

	// expected word stream, filled per accepted number and drained per word beat
	class word_scoreboard;
		word_beat_t pending[$];
		int         failures;

		function new();
			pending  = {};
			failures = 0;
		endfunction

		// append the words of one three-digit group
		function void spell_group(input int unsigned grp, ref logic [WORD_W-1:0] words[$]);
			int unsigned hund;
			int unsigned rest;
			hund = grp / 100;
			rest = grp % 100;
			if (hund != 0) begin
				words.push_back(WORD_W'(hund));
				words.push_back(W_HUNDRED);
			end
			if (rest != 0) begin
				if (rest < 20) begin
					words.push_back(WORD_W'(rest));
				end else begin
					words.push_back(W_TENS_OFS + WORD_W'(rest / 10));
					if (rest % 10 != 0)
						words.push_back(WORD_W'(rest % 10));
				end
			end
		endfunction

		// spell one accepted number into the expected stream
		function void note_number(input logic [VALUE_W-1:0] value);
			logic [WORD_W-1:0] words[$];
			int unsigned       v;
			int unsigned       bil;
			int unsigned       mil;
			int unsigned       thou;
			int unsigned       units;
			word_beat_t        beat;
			words = {};
			v     = value;
			bil   = v / 1000000000;
			v     = v % 1000000000;
			mil   = v / 1000000;
			v     = v % 1000000;
			thou  = v / 1000;
			units = v % 1000;
			if (value == '0)
				words.push_back(W_ZERO);
			if (bil != 0) begin
				spell_group(bil, words);
				words.push_back(W_BILLION);
			end
			if (mil != 0) begin
				spell_group(mil, words);
				words.push_back(W_MILLION);
			end
			if (thou != 0) begin
				spell_group(thou, words);
				words.push_back(W_THOUSAND);
			end
			if (units != 0)
				spell_group(units, words);
			foreach (words[i]) begin
				beat.word = words[i];
				beat.last = (i == words.size() - 1);
				pending.push_back(beat);
			end
		endfunction

		// compare one word beat with the oldest expected word
		function void check_word(input logic [WORD_W-1:0] word, input logic last);
			word_beat_t exp_beat;
			if (pending.size() == 0) begin
				$error("unexpected word beat: word %0d last %0b", word, last);
				failures++;
			end else begin
				exp_beat = pending.pop_front();
				if (word !== exp_beat.word) begin
					$error("word: expected %0d, actual %0d", exp_beat.word, word);
					failures++;
				end
				if (last !== exp_beat.last) begin
					$error("last: expected %0b, actual %0b", exp_beat.last, last);
					failures++;
				end
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	bit   calm;
	int   cycles;

	word_scoreboard sb;

	ntw_in_if  in_ch();
	ntw_out_if out_ch();

	number_to_word_tokens_top uut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic bit take_break();
		return !calm && ($urandom_range(99) < 13);
	endfunction

	// three-digit group with a bias toward zero, teens, round tens and round hundreds
	function automatic int unsigned pick_group();
		case ($urandom_range(5))
			0:       return 0;
			1:       return $urandom_range(19, 10);
			2:       return 10 * $urandom_range(9, 2);
			3:       return 100 * $urandom_range(9, 1);
			default: return $urandom_range(999);
		endcase
	endfunction

	function automatic logic [VALUE_W-1:0] pick_value();
		longint v;
		case ($urandom_range(19))
			0, 1, 2: return VALUE_W'($urandom());
			3, 4:    return VALUE_W'($urandom_range(1099));
			default: begin
				v = longint'($urandom_range(2)) * 1000000000 + longint'(pick_group()) * 1000000
					+ longint'(pick_group()) * 1000 + longint'(pick_group());
				if (v > VALUE_MAX)
					v = v - 1000000000;
				return VALUE_W'(v);
			end
		endcase
	endfunction

	// present one number, idling at random, and hold it until accepted
	task automatic send_number(input logic [VALUE_W-1:0] value);
		while (take_break()) begin
			in_ch.valid <= 1'b0;
			@(negedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.value <= value;
		do
			@(posedge clk);
		while (!in_ch.ready);
		@(negedge clk);
	endtask

	// receiver stalls at random once out of reset
	always @(negedge clk) begin
		if (arst_n)
			out_ch.ready <= !take_break();
	end

	// note accepted numbers
	always @(posedge clk) begin
		if (arst_n && in_ch.valid && in_ch.ready)
			sb.note_number(in_ch.value);
	end

	// check delivered words
	always @(posedge clk) begin
		if (arst_n && out_ch.valid && out_ch.ready)
			sb.check_word(out_ch.word, out_ch.last);
	end

	// bound the run
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	initial begin
		logic [VALUE_W-1:0] directed[$];
		sb = new();
		cycles = 0;
		calm = 1'b0;
		arst_n = 1'b0;
		in_ch.valid = 1'b0;
		in_ch.value = '0;
		out_ch.ready = 1'b0;
		directed = {
			31'd0, 31'd1, 31'd9, 31'd10, 31'd11, 31'd19, 31'd20, 31'd21, 31'd99,
			31'd100, 31'd101, 31'd110, 31'd119, 31'd999, 31'd1000, 31'd1001,
			31'd1000000, 31'd1000001, 31'd1100011, 31'd1000000000, 31'd1777777777,
			31'd2000000000, 31'd1073741824, 31'd2147483647
		};

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (directed[i])
			send_number(directed[i]);

		// random numbers, with a stretch of no idling on either side
		for (int i = 0; i < RANDOM_COUNT; i++) begin
			calm = (i >= 120 && i < 200);
			send_number(pick_value());
		end
		calm = 1'b0;
		in_ch.valid <= 1'b0;

		// drain expected words, then watch for strays
		while (sb.pending.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (sb.failures == 0 && sb.pending.size() == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule
